// ----- sv/tmet_pkg.sv -----
// Shared types, codes and default sizes of the tournament minimum-event tree.
package tmet_pkg;

    localparam int LEVELS_DEF       = 10;
    localparam int SINGLE_PAIRS_DEF = 300;
    localparam int TIME_W           = 32;
    localparam int IDX_W            = 10;
    localparam int OP_W             = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_BUILD  = 2'd1,
        OP_UPDATE = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UP,
        ST_BUILD,
        ST_DONE
    } t_state;

    // One tree node: time and the particle that owns it.
    typedef struct packed {
        logic [TIME_W-1:0] tm;
        logic [IDX_W-1:0]  win;
    } t_entry;

endpackage

// ----- sv/tmet_ifs.sv -----
// Valid/ready channel interfaces for the item input and the result output.
interface tmet_in_if import tmet_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  particle_index;
    logic [TIME_W-1:0] time_value;

    modport source (output valid, output op, output particle_index, output time_value,
                    input ready);
    modport sink   (input valid, input op, input particle_index, input time_value,
                    output ready);
endinterface

interface tmet_out_if import tmet_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] min_time;
    logic [IDX_W-1:0]  min_particle;
    logic              bad_index;

    modport source (output valid, output min_time, output min_particle, output bad_index,
                    input ready);
    modport sink   (input valid, input min_time, input min_particle, input bad_index,
                    output ready);
endinterface

// ----- sv/tmet_pick.sv -----
// Match unit: picks the winner of two children by time, tie to the chosen side.
module tmet_pick import tmet_pkg::*; (
    input  t_entry i_left,
    input  t_entry i_right,
    input  logic   i_left_tie,
    output t_entry o_win
);

    logic left_less;
    logic left_eq;

    // Compare times as unsigned values
    assign left_less = i_left.tm < i_right.tm;
    assign left_eq   = i_left.tm == i_right.tm;

    // Select the winner, tie resolved by i_left_tie
    assign o_win = (left_less || (i_left_tie && left_eq)) ? i_left : i_right;

endmodule

// ----- sv/tournament_min_event_tree_top.sv -----
// Top level of the tournament minimum-event tree: sequencer, leaf and node memories.
//
//  channel | dir | signals                                       | transfer when
//  i_in    | in  | op, particle_index, time_value                | valid & ready
//  o_out   | out | min_time, min_particle, bad_index             | valid & ready
//
// Load, rebuild of nothing (unused op), rejected index: straight to the final step.
// Update: one tree level per cycle through the node memory port.
// Rebuild: one internal node per cycle, read of the next node's children
// overlapped with the write of the current one.
// After reset a clearing pass zeroes the node memory; no item is taken
// during it. A finished result waits in the output register; the next item
// is accepted meanwhile, and the sequencer only holds at its final step
// while that register is still full.
module tournament_min_event_tree_top import tmet_pkg::*; #(
    parameter int LEVELS       = LEVELS_DEF,
    parameter int SINGLE_PAIRS = SINGLE_PAIRS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tmet_in_if.sink     i_in,
    tmet_out_if.source  o_out
);

    localparam int LEAVES    = 1 << LEVELS;
    localparam int ROWS      = LEAVES / 2;
    localparam int ROW_W     = LEVELS - 1;
    localparam int SINGLES   = 2 * SINGLE_PAIRS;
    localparam int PARTICLES = SINGLE_PAIRS + ROWS;
    localparam int WIDE_W    = 18;

    // Owner particle of a leaf
    function automatic logic [IDX_W-1:0] f_owner(input logic [LEVELS-1:0] leaf);
        logic [WIDE_W-1:0] l;
        logic [WIDE_W-1:0] s;
        logic [WIDE_W-1:0] sum;
        l   = WIDE_W'(leaf);
        s   = WIDE_W'(SINGLES);
        sum = l + s;
        return (l < s) ? l[IDX_W-1:0] : sum[IDX_W:1];
    endfunction

    // Leaf memory: one row holds two sibling leaves
    logic [TIME_W-1:0] r_leaf_lo [ROWS];
    logic [TIME_W-1:0] r_leaf_hi [ROWS];
    logic [TIME_W-1:0] r_leaf_rd_lo;
    logic [TIME_W-1:0] r_leaf_rd_hi;

    // Node memory: row p holds nodes 2p and 2p+1 (root is the high half of row 0)
    t_entry r_node_lo [ROWS];
    t_entry r_node_hi [ROWS];
    t_entry r_node_rd_lo;
    t_entry r_node_rd_hi;

    t_state             r_state,     n_state;
    logic [LEVELS-1:0]  r_k,         n_k;
    t_entry             r_cur,       n_cur;
    logic               r_cur_right, n_cur_right;
    logic               r_pair,      n_pair;
    logic [IDX_W-1:0]   r_sib_win,   n_sib_win;
    logic               r_bad,       n_bad;
    logic [ROW_W-1:0]   r_clr,       n_clr;
    t_entry             r_root,      n_root;
    t_entry             r_prev,      n_prev;
    logic               r_out_valid, n_out_valid;
    t_entry             r_out,       n_out;
    logic               r_out_bad,   n_out_bad;

    logic              leaf_we_lo;
    logic              leaf_we_hi;
    logic [ROW_W-1:0]  leaf_waddr;
    logic [ROW_W-1:0]  leaf_raddr;
    logic              node_we_lo;
    logic              node_we_hi;
    logic [ROW_W-1:0]  node_waddr;
    t_entry            node_wdata;
    logic [ROW_W-1:0]  node_raddr;

    logic              accept;
    logic              in_ok;
    logic              in_pair;
    logic [WIDE_W-1:0] in_wide;
    logic [LEVELS-1:0] in_leaf;

    t_entry            pick_l;
    t_entry            pick_r;
    logic              pick_ltie;
    t_entry            pick_w;
    t_entry            sib;
    logic              bottom;
    logic [LEVELS-1:0] km1;

    assign accept = i_in.valid && i_in.ready;
    assign bottom = r_k[LEVELS-1];
    assign km1    = r_k - 1'b1;

    // Decode the incoming particle into its first leaf
    always_comb begin
        in_ok   = 32'(i_in.particle_index) < PARTICLES;
        in_pair = 32'(i_in.particle_index) >= SINGLES;
        if (in_pair) begin
            in_wide = WIDE_W'({i_in.particle_index, 1'b0}) - WIDE_W'(SINGLES);
        end else begin
            in_wide = WIDE_W'(i_in.particle_index);
        end
        in_leaf = in_wide[LEVELS-1:0];
    end

    // Feed the match unit from the climbing value or the children rows
    always_comb begin
        if (bottom) begin
            sib.tm = r_pair ? r_cur.tm : (r_cur_right ? r_leaf_rd_lo : r_leaf_rd_hi);
        end else begin
            sib.tm = r_cur_right ? r_node_rd_lo.tm : r_node_rd_hi.tm;
        end
        sib.win = bottom ? r_sib_win : (r_cur_right ? r_node_rd_lo.win : r_node_rd_hi.win);
        if (r_state == ST_BUILD) begin
            pick_ltie = 1'b1;
            if (bottom) begin
                pick_l.tm  = r_leaf_rd_lo;
                pick_l.win = f_owner({r_k[ROW_W-1:0], 1'b0});
                pick_r.tm  = r_leaf_rd_hi;
                pick_r.win = f_owner({r_k[ROW_W-1:0], 1'b1});
            end else begin
                // node 2 is written in the same cycle its row is read for the root
                pick_l = (r_k == LEVELS'(1)) ? r_prev : r_node_rd_lo;
                pick_r = r_node_rd_hi;
            end
        end else begin
            pick_ltie = 1'b0;
            pick_l    = r_cur_right ? sib : r_cur;
            pick_r    = r_cur_right ? r_cur : sib;
        end
    end

    tmet_pick u_pick (
        .i_left     (pick_l),
        .i_right    (pick_r),
        .i_left_tie (pick_ltie),
        .o_win      (pick_w)
    );

    // Sequence items: next state, memory controls and outputs
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_cur       = r_cur;
        n_cur_right = r_cur_right;
        n_pair      = r_pair;
        n_sib_win   = r_sib_win;
        n_bad       = r_bad;
        n_clr       = r_clr;
        n_root      = r_root;
        n_prev      = r_prev;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_out_bad   = r_out_bad;

        leaf_we_lo  = 1'b0;
        leaf_we_hi  = 1'b0;
        leaf_waddr  = in_leaf[LEVELS-1:1];
        leaf_raddr  = in_leaf[LEVELS-1:1];
        node_we_lo  = 1'b0;
        node_we_hi  = 1'b0;
        node_waddr  = r_k[LEVELS-1:1];
        node_wdata  = pick_w;
        node_raddr  = r_k[LEVELS-1:1];

        // Drop the result once it transfers
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                node_we_lo = 1'b1;
                node_we_hi = 1'b1;
                node_waddr = r_clr;
                node_wdata = '0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == ROW_W'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_bad   = 1'b0;
                    n_state = ST_DONE;
                    case (i_in.op)
                        OP_LOAD, OP_UPDATE: begin
                            if (!in_ok) begin
                                n_bad = 1'b1;
                            end else begin
                                leaf_we_lo = in_pair || !in_leaf[0];
                                leaf_we_hi = in_pair || in_leaf[0];
                                if (i_in.op == OP_UPDATE) begin
                                    n_k         = {1'b1, in_leaf[LEVELS-1:1]};
                                    n_cur.tm    = i_in.time_value;
                                    n_cur.win   = f_owner(in_leaf);
                                    n_cur_right = in_leaf[0];
                                    n_sib_win   = f_owner(in_leaf ^ LEVELS'(1));
                                    n_pair      = in_pair;
                                    n_state     = ST_UP;
                                end
                            end
                        end
                        OP_BUILD: begin
                            leaf_raddr = '1;
                            n_k        = '1;
                            n_state    = ST_BUILD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_UP: begin
                // Write this level, read the row of its parent's children
                node_we_lo  = !r_k[0];
                node_we_hi  = r_k[0];
                n_cur       = pick_w;
                n_cur_right = r_k[0];
                n_k         = r_k >> 1;
                if (r_k == LEVELS'(1)) begin
                    n_root  = pick_w;
                    n_state = ST_DONE;
                end
            end
            ST_BUILD: begin
                // Write node k, read the children of node k-1
                node_we_lo = !r_k[0];
                node_we_hi = r_k[0];
                leaf_raddr = km1[ROW_W-1:0];
                node_raddr = km1[ROW_W-1:0];
                n_prev     = pick_w;
                n_k        = km1;
                if (r_k == LEVELS'(1)) begin
                    n_root  = pick_w;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_root;
                    n_out_bad   = r_bad;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_root      <= '0;
            r_out_valid <= 1'b0;
            r_bad       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_root      <= n_root;
            r_out_valid <= n_out_valid;
            r_bad       <= n_bad;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_cur       <= n_cur;
        r_cur_right <= n_cur_right;
        r_pair      <= n_pair;
        r_sib_win   <= n_sib_win;
        r_prev      <= n_prev;
        r_out       <= n_out;
        r_out_bad   <= n_out_bad;
    end

    // Leaf memory port
    always_ff @(posedge i_clk) begin
        if (leaf_we_lo) begin
            r_leaf_lo[leaf_waddr] <= i_in.time_value;
        end
        if (leaf_we_hi) begin
            r_leaf_hi[leaf_waddr] <= i_in.time_value;
        end
        r_leaf_rd_lo <= r_leaf_lo[leaf_raddr];
        r_leaf_rd_hi <= r_leaf_hi[leaf_raddr];
    end

    // Node memory port
    always_ff @(posedge i_clk) begin
        if (node_we_lo) begin
            r_node_lo[node_waddr] <= node_wdata;
        end
        if (node_we_hi) begin
            r_node_hi[node_waddr] <= node_wdata;
        end
        r_node_rd_lo <= r_node_lo[node_raddr];
        r_node_rd_hi <= r_node_hi[node_raddr];
    end

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.min_time     = r_out.tm;
    assign o_out.min_particle = r_out.win;
    assign o_out.bad_index    = r_out_bad;

    // Root changes only while the tree is being walked
    a_root_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE || r_state == ST_CLEAR)
        |=> $stable(r_root))
        else $error("root changed outside a tree walk");

    // The climb never walks past the root
    a_up_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UP || r_state == ST_BUILD) |-> (r_k != '0))
        else $error("node index reached zero during a walk");

    // A finished item lands in a free output register and releases the input
    a_done_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !r_out_valid) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("result not loaded from the final step");

    // A rejected index skips the tree entirely
    a_bad_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !in_ok && (i_in.op == OP_LOAD || i_in.op == OP_UPDATE))
        |=> (r_state == ST_DONE && r_bad))
        else $error("rejected item entered the tree");

endmodule
